// File: sv/clns_pkg.sv
// Shared types, constants and helper functions for the character display
// nibble strobe sequencer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package clns_pkg;

	// Request kinds
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_INIT  = 1'b1;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_SETUP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STROBE_SETTLE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_CMD       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_POWER_UP       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_GAP_FIRST = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_GAP_SECOND = 3'd5;
	localparam int CFG_DATA_W = 16;

	// Register reset values
	localparam logic [7:0]  RST_ENABLE_SETUP    = 8'd1;
	localparam logic [15:0] RST_STROBE_SETTLE   = 16'd45;
	localparam logic [15:0] RST_LONG_CMD        = 16'd2000;
	localparam logic [15:0] RST_POWER_UP        = 16'd20000;
	localparam logic [15:0] RST_INIT_GAP_FIRST  = 16'd5000;
	localparam logic [15:0] RST_INIT_GAP_SECOND = 16'd200;

	// Instruction codes below this value are clear or home
	localparam logic [7:0] LONG_CMD_LIMIT = 8'h04;

	// Initialization: wake-up nibbles, then the instruction list
	localparam logic [3:0] WAKE_NIBBLE    = 4'h3;
	localparam logic [3:0] FOUR_BIT_NIBBLE = 4'h2;
	localparam logic [3:0] INIT_LAST_STEP = 4'd15;
	localparam logic [3:0] WAKE_STEPS     = 4'd4;
	localparam logic [2:0] INIT_CMD_BASE  = 3'd2;

	// Job queue depth
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic       init;
		logic [7:0] data_byte;
		logic       reg_select;
		logic       long_cmd;
	} job_t;

	typedef struct packed {
		logic [7:0]  enable_setup_us;
		logic [15:0] strobe_settle_us;
		logic [15:0] long_cmd_us;
		logic [15:0] power_up_us;
		logic [15:0] init_gap_first_us;
		logic [15:0] init_gap_second_us;
	} cfg_t;

	typedef struct packed {
		logic [3:0]  data_nibble;
		logic        reg_select;
		logic [15:0] wait_before_us;
		logic [7:0]  pulse_us;
		logic [15:0] wait_after_us;
		logic        last;
	} strobe_t;

	// Instruction list sent after the wake-up nibbles
	function automatic logic [7:0] init_cmd(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h28;
			3'd1: c = 8'h08;
			3'd2: c = 8'h01;
			3'd3: c = 8'h0C;
			3'd4: c = 8'h02;
			3'd5: c = 8'h80;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// 16-bit add that clamps at all ones
	function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[16] ? 16'hFFFF : s[15:0];
	endfunction

endpackage

`default_nettype wire

// File: sv/clns_if.sv
// Valid/ready channel interfaces for requests and strobe descriptions.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface clns_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] data_byte;
	logic       is_char;

	modport source (output valid, req_type, data_byte, is_char, input ready);
	modport sink (input valid, req_type, data_byte, is_char, output ready);
endinterface

interface clns_stb_if;
	logic        valid;
	logic        ready;
	logic [3:0]  data_nibble;
	logic        reg_select;
	logic [15:0] wait_before_us;
	logic [7:0]  pulse_us;
	logic [15:0] wait_after_us;
	logic        last;

	modport source (output valid, data_nibble, reg_select, wait_before_us, pulse_us,
		wait_after_us, last, input ready);
	modport sink (input valid, data_nibble, reg_select, wait_before_us, pulse_us,
		wait_after_us, last, output ready);
endinterface

`default_nettype wire

// File: sv/clns_front.sv
// Front stage: takes requests and classifies them into jobs for the queue.
// Depends on clns_pkg and clns_if.
`timescale 1ns / 1ps
`default_nettype none

module clns_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	clns_req_if.sink           req,
	output clns_pkg::job_t     job,
	output logic               push,
	input  wire logic          full
);
	import clns_pkg::*;

	logic valid_s1;
	job_t job_s1;
	logic accept;

	// Stage frees up when empty or when its job moves into the queue
	assign push      = valid_s1 && !full;
	assign req.ready = !valid_s1 || !full;
	assign accept    = req.valid && req.ready;
	assign job       = job_s1;

	// Hold the valid flag of the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// Classify: initialization, or a byte write with a possible long wait
	always_ff @(posedge clk) begin
		if (accept) begin
			if (req.req_type == REQ_INIT) begin
				job_s1.init       <= 1'b1;
				job_s1.data_byte  <= 8'h00;
				job_s1.reg_select <= 1'b0;
				job_s1.long_cmd   <= 1'b0;
			end else begin
				job_s1.init       <= 1'b0;
				job_s1.data_byte  <= req.data_byte;
				job_s1.reg_select <= req.is_char;
				job_s1.long_cmd   <= !req.is_char && (req.data_byte < LONG_CMD_LIMIT);
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/clns_fifo.sv
// Short job queue between the front and back parts.
// Depends on clns_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clns_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire clns_pkg::job_t wr_job,
	output logic               full,
	input  wire logic          pop,
	output clns_pkg::job_t     rd_job,
	output logic               empty
);
	import clns_pkg::*;

	job_t                  mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	assign full   = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign empty  = (count_q == '0);
	assign rd_job = mem_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store pushed jobs
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

`default_nettype wire

// File: sv/clns_back.sv
// Back part: steps through the strobes of the job at the queue head and
// drives the output register. Depends on clns_pkg and clns_if.
`timescale 1ns / 1ps
`default_nettype none

module clns_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire clns_pkg::cfg_t cfg,
	input  wire clns_pkg::job_t job,
	input  wire logic          empty,
	output logic               pop,
	clns_stb_if.source         stb
);
	import clns_pkg::*;

	logic [3:0] step_q;
	logic       out_valid_q;
	strobe_t    out_q;
	strobe_t    nxt;
	logic       advance;
	logic       load;
	logic [7:0] cmd;
	logic       long_wait;
	logic [15:0] before_add;
	logic [15:0] after_add;

	assign advance = !out_valid_q || stb.ready;
	assign load    = advance && !empty;
	assign pop     = load && nxt.last;

	// Describe the strobe for the current step of the head job
	always_comb begin
		cmd        = job.data_byte;
		long_wait  = 1'b0;
		before_add = '0;
		after_add  = '0;
		nxt.reg_select = job.reg_select;
		nxt.pulse_us   = cfg.enable_setup_us;
		nxt.last       = step_q[0];
		if (job.init) begin
			nxt.reg_select = 1'b0;
			nxt.last       = (step_q == INIT_LAST_STEP);
			cmd            = init_cmd(step_q[3:1] - INIT_CMD_BASE);
			long_wait      = step_q[0] && (cmd < LONG_CMD_LIMIT);
		end else begin
			long_wait = step_q[0] && job.long_cmd;
		end
		nxt.data_nibble = step_q[0] ? cmd[3:0] : cmd[7:4];
		if (job.init && step_q < WAKE_STEPS) begin
			nxt.data_nibble = (step_q == 4'd3) ? FOUR_BIT_NIBBLE : WAKE_NIBBLE;
			long_wait       = 1'b0;
			if (step_q == 4'd0) begin
				before_add = cfg.power_up_us;
				after_add  = cfg.init_gap_first_us;
			end else if (step_q == 4'd1) begin
				after_add = cfg.init_gap_second_us;
			end
		end
		if (long_wait) begin
			after_add = cfg.long_cmd_us;
		end
		nxt.wait_before_us = sat_add16({8'h00, cfg.enable_setup_us}, before_add);
		nxt.wait_after_us  = sat_add16(cfg.strobe_settle_us, after_add);
	end

	// Advance the step counter; wrap when the job leaves the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= !empty;
			if (load) begin
				step_q <= nxt.last ? 4'd0 : step_q + 4'd1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= nxt;
		end
	end

	assign stb.valid          = out_valid_q;
	assign stb.data_nibble    = out_q.data_nibble;
	assign stb.reg_select     = out_q.reg_select;
	assign stb.wait_before_us = out_q.wait_before_us;
	assign stb.pulse_us       = out_q.pulse_us;
	assign stb.wait_after_us  = out_q.wait_after_us;
	assign stb.last           = out_q.last;

endmodule

`default_nettype wire

// File: sv/char_lcd_nibble_strobe_sequencer_core.sv
// Character display nibble strobe sequencer, top level.
// Channels: req (sink) takes a byte write or an initialization request;
// stb (source) gives one strobe description per enable pulse, with last set
// on the final strobe of each request. A byte write yields two strobes (high
// nibble, then low nibble); an initialization yields sixteen.
// cfg_we/cfg_index/cfg_data write the six timing registers; writes to an
// index past the list are dropped. Write them only while the block is idle.
// The first strobe of a request goes from its transfer through the front
// stage, the job queue and then the output register.
// Throughput: one strobe per cycle while the receiver is ready, set by the
// back part's step counter; the front keeps taking requests until the
// front stage and the four-entry job queue are both full.
// Reset clears the front stage, queue and output valid flag and loads the
// registers with their defaults. When the receiver stalls, the output holds
// and the back part waits; requests still land in the queue until it fills.
// Depends on clns_pkg, clns_if, clns_front, clns_fifo and clns_back.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_nibble_strobe_sequencer_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	clns_req_if.sink                           req,
	clns_stb_if.source                         stb,
	input  wire logic                          cfg_we,
	input  wire logic [clns_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [clns_pkg::CFG_DATA_W-1:0] cfg_data
);
	import clns_pkg::*;

	cfg_t cfg_q;
	job_t front_job;
	job_t head_job;
	logic push;
	logic full;
	logic pop;
	logic empty;

	// Timing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable_setup_us    <= RST_ENABLE_SETUP;
			cfg_q.strobe_settle_us   <= RST_STROBE_SETTLE;
			cfg_q.long_cmd_us        <= RST_LONG_CMD;
			cfg_q.power_up_us        <= RST_POWER_UP;
			cfg_q.init_gap_first_us  <= RST_INIT_GAP_FIRST;
			cfg_q.init_gap_second_us <= RST_INIT_GAP_SECOND;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ENABLE_SETUP:    cfg_q.enable_setup_us    <= cfg_data[7:0];
				CFG_STROBE_SETTLE:   cfg_q.strobe_settle_us   <= cfg_data;
				CFG_LONG_CMD:        cfg_q.long_cmd_us        <= cfg_data;
				CFG_POWER_UP:        cfg_q.power_up_us        <= cfg_data;
				CFG_INIT_GAP_FIRST:  cfg_q.init_gap_first_us  <= cfg_data;
				CFG_INIT_GAP_SECOND: cfg_q.init_gap_second_us <= cfg_data;
				default: ;
			endcase
		end
	end

	clns_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.job    (front_job),
		.push   (push),
		.full   (full)
	);

	clns_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (front_job),
		.full   (full),
		.pop    (pop),
		.rd_job (head_job),
		.empty  (empty)
	);

	clns_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.job    (head_job),
		.empty  (empty),
		.pop    (pop),
		.stb    (stb)
	);

	// Queue is never pushed when full nor popped when empty
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("job queue pushed while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("job queue popped while empty");

	// Pulse width always reflects the setup register
	a_pulse_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		stb.valid |-> (stb.pulse_us == cfg_q.enable_setup_us))
		else $error("pulse width differs from setup register");

endmodule

`default_nettype wire
